[src/assert_macros.svh]
// Assertion macros shared by the stack machine RTL.
// Depends on a clock named clk and a reset named rst in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication checked at every clock edge out of reset.
`define ASSERT_IMPL(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

`endif

[src/ism_pkg.sv]
// Package for the integer stack machine: opcodes, controller states,
// command and status structs between controller and datapath. No dependencies.
package ism_pkg;

  localparam int STACK_DEPTH_DEF = 64;
  localparam int DATA_W          = 32;
  localparam int OP_W            = 4;
  localparam int DEPTH_OUT_W     = 7;
  localparam int DIV_STEPS       = 32;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH = 4'd0,
    OP_DROP = 4'd1,
    OP_DUP  = 4'd2,
    OP_SWAP = 4'd3,
    OP_ADD  = 4'd4,
    OP_SUB  = 4'd5,
    OP_MUL  = 4'd6,
    OP_DIV  = 4'd7,
    OP_MOD  = 4'd8,
    OP_EQ   = 4'd9,
    OP_NE   = 4'd10,
    OP_GT   = 4'd11,
    OP_GE   = 4'd12,
    OP_LT   = 4'd13,
    OP_LE   = 4'd14,
    OP_OUT  = 4'd15
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DIV,
    S_ZREAD
  } state_t;

  typedef enum logic {
    ADDR_SECOND,
    ADDR_THIRD
  } addr_sel_t;

  typedef struct packed {
    logic      capture;
    logic      commit;
    logic      div_start;
    addr_sel_t addr_sel;
  } cmd_t;

  typedef struct packed {
    logic is_div;
    logic zdiv;
    logic div_done;
    logic out_free;
  } stat_t;

endpackage

[src/ism_div.sv]
// Iterative restoring divider for unsigned 32-bit magnitudes, one quotient bit a cycle.
// Depends on ism_pkg.
module ism_div import ism_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DATA_W-1:0] dividend,
  input  logic [DATA_W-1:0] divisor,
  output logic [DATA_W-1:0] quotient,
  output logic [DATA_W-1:0] remainder,
  output logic              done
);

  localparam int CNTW = $clog2(DIV_STEPS + 1);

  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] quo;
  logic [DATA_W-1:0] dvs;
  logic [CNTW-1:0]   cnt;
  logic              busy;
  logic [DATA_W:0]   rem_shift;
  logic [DATA_W:0]   diff;

  assign rem_shift = {rem, quo[DATA_W-1]};
  assign diff      = rem_shift - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= CNTW'(DIV_STEPS);
    end else if (busy) begin
      cnt <= cnt - CNTW'(1);
      if (cnt == CNTW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      if (!diff[DATA_W]) begin
        rem <= diff[DATA_W-1:0];
        quo <= {quo[DATA_W-2:0], 1'b1};
      end else begin
        rem <= rem_shift[DATA_W-1:0];
        quo <= {quo[DATA_W-2:0], 1'b0};
      end
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

[src/ism_dpath.sv]
// Datapath: top-of-stack register, stack memory below it, count, ALU and result register.
// Depends on ism_pkg, ism_div and assert_macros.svh.
`include "assert_macros.svh"
module ism_dpath import ism_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [OP_W-1:0]        opcode,
  input  logic [DATA_W-1:0]      literal,
  input  cmd_t                   cmd,
  output stat_t                  st,
  input  logic                   res_stall,
  output logic                   res_valid,
  output logic [DATA_W-1:0]      top_value,
  output logic [DEPTH_OUT_W-1:0] stack_depth,
  output logic [DATA_W-1:0]      printed_value,
  output logic                   printed_valid,
  output logic                   underflow_seen,
  output logic                   overflow_seen,
  output logic                   zero_divisor
);

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);

  logic [DATA_W-1:0] mem [STACK_DEPTH];
  logic [DATA_W-1:0] rd_data;
  logic [AW-1:0]     rd_addr;

  op_t               op_q;
  logic [DATA_W-1:0] lit_q;
  logic [DATA_W-1:0] top;
  logic [DATA_W-1:0] top_next;
  logic [CW-1:0]     count;
  logic [CW-1:0]     count_next;

  logic [CW-1:0] cm1, cm2, cm3, base;
  logic          is_empty, lt2, lt3, full, is_div, zdiv;

  logic [DATA_W-1:0] opa, opb, mag_a, mag_b, prod, quo, rem, quo_s, rem_s, alu_res;
  logic              div_done;

  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [DATA_W-1:0] wr_data;
  logic              under, over, zdv, pvalid;
  logic [DATA_W-1:0] printed;

  assign cm1      = count - CW'(1);
  assign cm2      = count - CW'(2);
  assign cm3      = count - CW'(3);
  assign is_empty = (count == '0);
  assign lt2      = (count < CW'(2));
  assign lt3      = (count < CW'(3));
  assign full     = (count == CW'(STACK_DEPTH));
  assign base     = lt2 ? '0 : cm2;

  assign rd_addr = (cmd.addr_sel == ADDR_THIRD) ? cm3[AW-1:0] : cm2[AW-1:0];

  assign opa   = lt2 ? '0 : rd_data;
  assign opb   = top;
  assign mag_a = opa[DATA_W-1] ? (DATA_W'(0) - opa) : opa;
  assign mag_b = opb[DATA_W-1] ? (DATA_W'(0) - opb) : opb;
  assign prod  = opa * opb;
  assign quo_s = (opa[DATA_W-1] ^ opb[DATA_W-1]) ? (DATA_W'(0) - quo) : quo;
  assign rem_s = opa[DATA_W-1] ? (DATA_W'(0) - rem) : rem;

  assign is_div = (op_q == OP_DIV) || (op_q == OP_MOD);
  assign zdiv   = (top == '0);

  ism_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (mag_a),
    .divisor   (mag_b),
    .quotient  (quo),
    .remainder (rem),
    .done      (div_done)
  );

  always_comb begin
    alu_res = '0;
    unique case (op_q)
      OP_ADD:  alu_res = opa + opb;
      OP_SUB:  alu_res = opa - opb;
      OP_MUL:  alu_res = prod;
      OP_DIV:  alu_res = quo_s;
      OP_MOD:  alu_res = rem_s;
      OP_EQ:   alu_res = DATA_W'(opa == opb);
      OP_NE:   alu_res = DATA_W'(opa != opb);
      OP_GT:   alu_res = DATA_W'($signed(opa) > $signed(opb));
      OP_GE:   alu_res = DATA_W'($signed(opa) >= $signed(opb));
      OP_LT:   alu_res = DATA_W'($signed(opa) < $signed(opb));
      OP_LE:   alu_res = DATA_W'($signed(opa) <= $signed(opb));
      OP_PUSH, OP_DROP, OP_DUP, OP_SWAP, OP_OUT: alu_res = '0;
    endcase
  end

  always_comb begin
    top_next   = top;
    count_next = count;
    wr_en      = 1'b0;
    wr_addr    = cm1[AW-1:0];
    wr_data    = top;
    under      = 1'b0;
    over       = 1'b0;
    zdv        = 1'b0;
    pvalid     = 1'b0;
    printed    = '0;
    unique case (op_q)
      OP_PUSH: begin
        if (full) begin
          over = 1'b1;
        end else begin
          wr_en      = !is_empty;
          top_next   = lit_q;
          count_next = count + CW'(1);
        end
      end
      OP_DROP, OP_OUT: begin
        if (op_q == OP_OUT) begin
          printed = top;
          pvalid  = 1'b1;
        end
        if (is_empty) begin
          under = 1'b1;
        end else begin
          count_next = cm1;
          top_next   = opa;
        end
      end
      OP_DUP: begin
        if (is_empty) begin
          under      = 1'b1;
          wr_en      = 1'b1;
          wr_addr    = '0;
          wr_data    = '0;
          top_next   = '0;
          count_next = CW'(2);
        end else if (full) begin
          over = 1'b1;
        end else begin
          wr_en      = 1'b1;
          count_next = count + CW'(1);
        end
      end
      OP_SWAP: begin
        under      = lt2;
        wr_en      = 1'b1;
        wr_addr    = lt2 ? '0 : cm2[AW-1:0];
        top_next   = opa;
        count_next = lt2 ? CW'(2) : count;
      end
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_EQ, OP_NE,
      OP_GT, OP_GE, OP_LT, OP_LE: begin
        under = lt2;
        if (is_div && zdiv) begin
          zdv        = 1'b1;
          count_next = base;
          top_next   = lt3 ? '0 : rd_data;
        end else begin
          top_next   = alu_res;
          count_next = base + CW'(1);
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      top   <= '0;
      count <= '0;
    end else if (cmd.commit) begin
      top   <= top_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q  <= op_t'(opcode);
      lit_q <= literal;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.commit) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      top_value      <= top_next;
      stack_depth    <= DEPTH_OUT_W'(count_next);
      printed_value  <= printed;
      printed_valid  <= pvalid;
      underflow_seen <= under;
      overflow_seen  <= over;
      zero_divisor   <= zdv;
    end
  end

  assign st.is_div   = is_div;
  assign st.zdiv     = zdiv;
  assign st.div_done = div_done;
  assign st.out_free = !res_valid || !res_stall;

  `ASSERT_ALWAYS(a_count_range, count <= CW'(STACK_DEPTH), "stack count beyond depth")
  `ASSERT_IMPL(a_empty_top, count == '0, top == '0, "top register not clear on empty stack")

endmodule

[src/ism_ctrl.sv]
// Controller: sequences accept, execute, divide wait and reload of the top register.
// Depends on ism_pkg and assert_macros.svh.
`include "assert_macros.svh"
module ism_ctrl import ism_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  req_valid,
  output logic  req_stall,
  input  stat_t st,
  output cmd_t  cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (st.is_div && st.zdiv) begin
          state_next = S_ZREAD;
        end else if (st.is_div) begin
          state_next = S_DIV;
        end else if (st.out_free) begin
          state_next = S_IDLE;
        end
      end
      S_DIV: begin
        if (st.div_done && st.out_free) state_next = S_IDLE;
      end
      S_ZREAD: begin
        if (st.out_free) state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    req_stall     = 1'b1;
    cmd.capture   = 1'b0;
    cmd.commit    = 1'b0;
    cmd.div_start = 1'b0;
    cmd.addr_sel  = ADDR_SECOND;
    unique case (state)
      S_IDLE: begin
        req_stall   = 1'b0;
        cmd.capture = req_valid;
      end
      S_EXEC: begin
        if (st.is_div && st.zdiv) begin
          cmd.addr_sel = ADDR_THIRD;
        end else if (st.is_div) begin
          cmd.div_start = 1'b1;
        end else begin
          cmd.commit = st.out_free;
        end
      end
      S_DIV: begin
        cmd.commit = st.div_done && st.out_free;
      end
      S_ZREAD: begin
        cmd.addr_sel = ADDR_THIRD;
        cmd.commit   = st.out_free;
      end
    endcase
  end

  `ASSERT_IMPL(a_commit_free, cmd.commit, st.out_free, "commit while result register busy")
  `ASSERT_IMPL(a_div_hold, state == S_DIV && !st.div_done, !cmd.commit, "commit before quotient")
  `ASSERT_IMPL(a_start_exec, cmd.div_start, state == S_EXEC && !st.zdiv, "divider started badly")

endmodule

[src/integer_stack_machine_alu_unit.sv]
// Integer stack machine: executes one 32-bit stack instruction per request.
// Usage:
//   Request channel req_valid/req_stall carries opcode and literal. A request
//   is taken at a rising edge with req_valid high and req_stall low.
//   Result channel res_valid/res_stall carries the new top, depth, printed
//   value and the per-instruction flags; one result per request.
// Sequencing:
//   Ordinary instructions: accept, then an execute step that uses the entry
//   below the top, read from the stack memory, and writes back. Div and mod
//   with a nonzero divisor: accept, execute, then a divide wait on the
//   divider, one quotient bit a cycle. Div or mod by zero: one extra memory
//   read to reload the new top. No request is taken before the last commits.
//   The next request is accepted while a result waits in the output register.
// Reset: synchronous; empties the stack and clears the result valid flag.
//   Stack memory contents are not cleared and need no clearing pass.
// Stall: while res_stall holds a result, the block finishes the request in
//   hand and waits before committing it; req_stall stays high meanwhile.
// Depends on ism_pkg, ism_ctrl, ism_dpath.
module integer_stack_machine_alu_unit import ism_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   req_valid,
  output logic                   req_stall,
  input  logic [OP_W-1:0]        opcode,
  input  logic [DATA_W-1:0]      literal,
  output logic                   res_valid,
  input  logic                   res_stall,
  output logic [DATA_W-1:0]      top_value,
  output logic [DEPTH_OUT_W-1:0] stack_depth,
  output logic [DATA_W-1:0]      printed_value,
  output logic                   printed_valid,
  output logic                   underflow_seen,
  output logic                   overflow_seen,
  output logic                   zero_divisor
);

  cmd_t  cmd;
  stat_t st;

  ism_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .st        (st),
    .cmd       (cmd)
  );

  ism_dpath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dpath (
    .clk            (clk),
    .rst            (rst),
    .opcode         (opcode),
    .literal        (literal),
    .cmd            (cmd),
    .st             (st),
    .res_stall      (res_stall),
    .res_valid      (res_valid),
    .top_value      (top_value),
    .stack_depth    (stack_depth),
    .printed_value  (printed_value),
    .printed_valid  (printed_valid),
    .underflow_seen (underflow_seen),
    .overflow_seen  (overflow_seen),
    .zero_divisor   (zero_divisor)
  );

endmodule

[bench/integer_stack_machine_alu_unit_test.sv]
`timescale 1ns / 100ps
// Self-checking bench for integer_stack_machine_alu_unit: a queue-fed driver,
// a clocked monitor and a stack-machine predictor, run through several idle mixes.
// Depends on ism_pkg and the integer_stack_machine_alu_unit RTL.
module integer_stack_machine_alu_unit_test import ism_pkg::*; ();

  localparam int DEPTH = STACK_DEPTH_DEF;

  typedef struct {
    op_t         op;
    logic [31:0] lit;
  } instr_t;

  typedef struct packed {
    logic [31:0] top;
    logic [6:0]  depth;
    logic [31:0] printed;
    logic        pvalid;
    logic        under;
    logic        over;
    logic        zdiv;
  } result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  logic [3:0]  opcode = '0;
  logic [31:0] literal = '0;
  logic        res_valid;
  logic        res_stall = 1'b0;
  logic [31:0] top_value;
  logic [6:0]  stack_depth;
  logic [31:0] printed_value;
  logic        printed_valid;
  logic        underflow_seen;
  logic        overflow_seen;
  logic        zero_divisor;

  instr_t      instr_q[$];
  result_t     predicted_results[$];

  logic [31:0] stack_img [DEPTH];
  int          depth_now = 0;
  logic        pop_under;
  logic        push_over;

  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  logic        res_hold = 1'b0;

  int          err_cnt = 0;
  int          accepted_cnt = 0;
  int          checked_cnt = 0;
  int          under_hits = 0;
  int          over_hits = 0;
  int          zdiv_hits = 0;
  int          print_hits = 0;
  int          peak_depth = 0;
  int          queued_cnt = 0;

  integer_stack_machine_alu_unit dut (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (req_valid),
    .req_stall      (req_stall),
    .opcode         (opcode),
    .literal        (literal),
    .res_valid      (res_valid),
    .res_stall      (res_stall),
    .top_value      (top_value),
    .stack_depth    (stack_depth),
    .printed_value  (printed_value),
    .printed_valid  (printed_valid),
    .underflow_seen (underflow_seen),
    .overflow_seen  (overflow_seen),
    .zero_divisor   (zero_divisor)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic logic [31:0] pop_word();
    if (depth_now == 0) begin
      pop_under = 1'b1;
      return '0;
    end
    depth_now--;
    return stack_img[depth_now];
  endfunction

  function automatic void push_word(logic [31:0] v);
    if (depth_now >= DEPTH) begin
      push_over = 1'b1;
    end else begin
      stack_img[depth_now] = v;
      depth_now++;
      if (depth_now > peak_depth) peak_depth = depth_now;
    end
  endfunction

  function automatic result_t execute_instr(op_t op, logic [31:0] lit);
    logic [31:0] a;
    logic [31:0] b;
    longint      sa;
    longint      sb;
    result_t     r;
    r = '0;
    pop_under = 1'b0;
    push_over = 1'b0;
    case (op)
      OP_PUSH: push_word(lit);
      OP_DROP: void'(pop_word());
      OP_DUP: begin
        a = pop_word();
        push_word(a);
        push_word(a);
      end
      OP_SWAP: begin
        b = pop_word();
        a = pop_word();
        push_word(b);
        push_word(a);
      end
      OP_OUT: begin
        r.printed = pop_word();
        r.pvalid = 1'b1;
      end
      default: begin
        b = pop_word();
        a = pop_word();
        sa = $signed(a);
        sb = $signed(b);
        case (op)
          OP_ADD: push_word(a + b);
          OP_SUB: push_word(a - b);
          OP_MUL: push_word(a * b);
          OP_DIV, OP_MOD: begin
            if (b == '0) r.zdiv = 1'b1;
            else if (op == OP_DIV) push_word(32'(sa / sb));
            else push_word(32'(sa % sb));
          end
          OP_EQ: push_word({31'd0, a == b});
          OP_NE: push_word({31'd0, a != b});
          OP_GT: push_word({31'd0, sa > sb});
          OP_GE: push_word({31'd0, sa >= sb});
          OP_LT: push_word({31'd0, sa < sb});
          default: push_word({31'd0, sa <= sb});
        endcase
      end
    endcase
    r.top = (depth_now > 0) ? stack_img[depth_now - 1] : '0;
    r.depth = 7'(depth_now);
    r.under = pop_under;
    r.over = push_over;
    under_hits += pop_under;
    over_hits += push_over;
    zdiv_hits += r.zdiv;
    print_hits += r.pvalid;
    return r;
  endfunction

  always @(posedge clk) begin : drive
    instr_t nxt;
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && !req_stall) begin
        predicted_results.push_back(execute_instr(op_t'(opcode), literal));
        accepted_cnt++;
      end
      if (!req_valid || !req_stall) begin
        if (instr_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt = instr_q.pop_front();
          req_valid <= 1'b1;
          opcode <= nxt.op;
          literal <= nxt.lit;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : watch
    result_t got;
    result_t want;
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      if (res_valid && !res_stall) begin
        got = {top_value, stack_depth, printed_value, printed_valid,
               underflow_seen, overflow_seen, zero_divisor};
        if (predicted_results.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10) $display("unexpected result: top=%h depth=%0d", got.top, got.depth);
        end else begin
          want = predicted_results.pop_front();
          if (got !== want) begin
            err_cnt++;
            if (err_cnt <= 10) begin
              $display("result %0d mismatch: expected top=%h depth=%0d printed=%h/%b flags=%b%b%b",
                       checked_cnt, want.top, want.depth, want.printed, want.pvalid,
                       want.under, want.over, want.zdiv);
              $display("result %0d mismatch: actual   top=%h depth=%0d printed=%h/%b flags=%b%b%b",
                       checked_cnt, got.top, got.depth, got.printed, got.pvalid,
                       got.under, got.over, got.zdiv);
            end
          end
          checked_cnt++;
        end
      end
      res_stall <= res_hold || ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 7))
      0: return 32'd0;
      1: return 32'd1;
      2: return 32'hFFFF_FFFF;
      3: return 32'h8000_0000;
      4: return 32'h7FFF_FFFF;
      5: return 32'($urandom_range(0, 20)) - 32'd10;
      default: return $urandom;
    endcase
  endfunction

  function automatic void add_instr(op_t op, logic [31:0] lit);
    instr_t it;
    it.op = op;
    it.lit = lit;
    instr_q.push_back(it);
    queued_cnt++;
  endfunction

  task automatic queue_random(int budget);
    int start;
    int n;
    int k;
    start = queued_cnt;
    while (queued_cnt - start < budget) begin
      case ($urandom_range(0, 3))
        0: begin
          n = $urandom_range(60, 72);
          for (k = 0; k < n; k++)
            add_instr(($urandom_range(0, 9) == 0) ? OP_DUP : OP_PUSH, rand_word());
        end
        1: begin
          n = $urandom_range(40, 72);
          for (k = 0; k < n; k++) add_instr(op_t'($urandom_range(1, 15)), $urandom);
        end
        2: begin
          n = $urandom_range(20, 40);
          for (k = 0; k < n; k++) add_instr(op_t'($urandom_range(0, 15)), rand_word());
        end
        default: begin
          n = $urandom_range(6, 12);
          for (k = 0; k < n; k++) begin
            add_instr(OP_PUSH, rand_word());
            add_instr(OP_PUSH, rand_word());
            add_instr(op_t'($urandom_range(4, 14)), $urandom);
            if ($urandom_range(0, 3) == 0) add_instr(OP_OUT, $urandom);
          end
        end
      endcase
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (instr_q.size() != 0 || req_valid || predicted_results.size() != 0);
  endtask

  task automatic run_phase(int budget, int idle_pct, int stall_pct);
    @(negedge clk);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    queue_random(budget);
    wait_idle();
  endtask

  initial begin : stimulus
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    add_instr(OP_DROP, 32'h0);
    add_instr(OP_OUT, 32'hFFFF_FFFF);
    add_instr(OP_DUP, 32'h0);
    add_instr(OP_SWAP, 32'h0);
    add_instr(OP_SUB, 32'h0);
    add_instr(OP_PUSH, 32'h8000_0000);
    add_instr(OP_DUP, 32'h0);
    add_instr(OP_PUSH, 32'hFFFF_FFFF);
    add_instr(OP_DIV, 32'h0);
    add_instr(OP_PUSH, 32'hFFFF_FFFF);
    add_instr(OP_MOD, 32'h0);
    add_instr(OP_DIV, 32'h0);
    add_instr(OP_PUSH, 32'h7FFF_FFFF);
    add_instr(OP_PUSH, 32'h0);
    add_instr(OP_MOD, 32'h0);
    add_instr(OP_PUSH, 32'h7FFF_FFFF);
    add_instr(OP_DUP, 32'h0);
    add_instr(OP_MUL, 32'h0);
    add_instr(OP_PUSH, 32'hFFFF_FFFF);
    add_instr(OP_GT, 32'h0);
    add_instr(OP_PUSH, 32'h8000_0000);
    add_instr(OP_LT, 32'h0);
    add_instr(OP_GE, 32'h0);
    add_instr(OP_DUP, 32'h0);
    add_instr(OP_LE, 32'h0);
    add_instr(OP_DUP, 32'h0);
    add_instr(OP_EQ, 32'h0);
    add_instr(OP_NE, 32'h0);
    add_instr(OP_PUSH, 32'h7FFF_FFFF);
    add_instr(OP_ADD, 32'h0);
    add_instr(OP_OUT, 32'h0);
    wait_idle();

    run_phase(300, 0, 0);
    run_phase(230, 81, 0);
    run_phase(230, 0, 81);
    run_phase(230, 25, 25);

    // hold the result side while requests keep coming, so the block backs up
    @(negedge clk);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    queue_random(200);
    res_hold = 1'b1;
    repeat (400) @(negedge clk);
    res_hold = 1'b0;
    wait_idle();

    repeat (40) @(negedge clk);
    $display("ran %0d requests over six idle mixes, %0d results checked, peak depth %0d",
             accepted_cnt, checked_cnt, peak_depth);
    $display("underflows %0d, overflows %0d, zero divisors %0d, printed values %0d",
             under_hits, over_hits, zdiv_hits, print_hits);
    if (err_cnt == 0) begin
      $display("integer_stack_machine_alu_unit_test: clean");
    end else begin
      $display("mismatches: %0d", err_cnt);
      $display("integer_stack_machine_alu_unit_test: errors");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("timed out with %0d results outstanding", predicted_results.size());
    $display("integer_stack_machine_alu_unit_test: errors");
    $finish;
  end

endmodule
